FILE: rtl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants of the round-robin task scheduler
// Request payloads, task state codes, opcodes and controller/datapath links.
// ----------------------------------------------------------------------------
package rrts_pkg;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_YIELD     = 3'd1,
    OP_SLEEP     = 3'd2,
    OP_SUSPEND   = 3'd3,
    OP_RESUME    = 3'd4,
    OP_TERMINATE = 3'd5,
    OP_EXIT      = 3'd6,
    OP_USAGE     = 3'd7
  } opcode_t;

  localparam logic [2:0] ST_READY      = 3'd0;
  localparam logic [2:0] ST_RUNNING    = 3'd1;
  localparam logic [2:0] ST_BLOCKED    = 3'd2;
  localparam logic [2:0] ST_SUSPENDED  = 3'd3;
  localparam logic [2:0] ST_TERMINATED = 3'd4;

  localparam logic [0:0] CFG_TASKS = 1'd0;
  localparam logic [0:0] CFG_STEP  = 1'd1;

  localparam int unsigned PCT_SCALE = 100;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  task_id;
    logic [31:0] sleep_ms;
  } req_t;

  typedef struct packed {
    logic [3:0]  running_task;
    logic        running_valid;
    logic        switched;
    logic        status;
    logic [6:0]  usage_percent;
    logic [31:0] task_run_ticks;
    logic [2:0]  addressed_state;
  } rsp_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;       // capture request, apply opcode front half
    logic wake_step;  // wake test on the scan slot
    logic pick_step;  // round-robin test on the scan slot
    logic commit;     // perform switch from pick result
    logic div_start;  // begin usage division
    logic div_step;   // one restoring division bit
    logic finish;     // build response
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic need_sched;
    logic need_div;
    logic scan_last;
    logic pick_found;
    logic div_last;
  } sts_t;

endpackage

FILE: rtl/rrts_ctrl.sv
// ----------------------------------------------------------------------------
// rrts_ctrl: scheduler sequencer
// Steps each request through load, then wake scan, pick scan and commit, or division, then response.
// ----------------------------------------------------------------------------
module rrts_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  logic            out_busy,
  input  rrts_pkg::sts_t  sts,
  output rrts_pkg::cmd_t  cmd,
  output logic            idle
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_WAKE, S_PICK, S_COMMIT, S_DIV, S_DONE
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.need_sched) state_next = S_WAKE;
        else if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else state_next = S_DONE;
      end
      S_WAKE: begin
        cmd.wake_step = 1'b1;
        if (sts.scan_last) state_next = S_PICK;
      end
      S_PICK: begin
        cmd.pick_step = 1'b1;
        if (sts.scan_last || sts.pick_found) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign idle = (state == S_IDLE);

  a_load_from_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> $past(state_next == S_IDLE || rst) || state == S_IDLE)
    else $error("load outside idle");
  a_finish_returns: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> state == S_IDLE)
    else $error("finish did not return to idle");
  a_no_fire_busy: assert property (@(posedge clk) disable iff (rst)
    !idle |-> !cmd.load)
    else $error("request loaded while busy");

endmodule

FILE: rtl/rrts_dp.sv
// ----------------------------------------------------------------------------
// rrts_dp: scheduler datapath
// Task tables, system time, scan counter and a bit-serial usage divider.
// ----------------------------------------------------------------------------
module rrts_dp #(
  parameter int TASK_SLOTS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  rrts_pkg::cmd_t  cmd,
  input  rrts_pkg::req_t  req,
  input  logic            cfg_we,
  input  logic            cfg_idx,
  input  logic [9:0]      cfg_data,
  output rrts_pkg::sts_t  sts,
  output rrts_pkg::rsp_t  rsp
);

  localparam int IW = $clog2(TASK_SLOTS);
  localparam int CW = $clog2(TASK_SLOTS + 1);

  logic [2:0]  tstate [TASK_SLOTS];
  logic [31:0] wake   [TASK_SLOTS];
  logic [31:0] runt   [TASK_SLOTS];
  logic [31:0] ltot   [TASK_SLOTS];
  logic [31:0] lrun   [TASK_SLOTS];
  logic [31:0] systime;
  logic [IW-1:0] cur;
  logic          cur_ok;
  logic [4:0]    tasks_cfg;
  logic [9:0]    step_cfg;

  logic [3:0]  tid;
  logic        stat, sw;
  logic        need_sched, need_div;
  logic [CW-1:0] k;
  logic [CW-1:0] cnd;   // pick candidate, walks (cur + k) mod n
  logic          found;
  logic [IW-1:0] pick_idx;
  logic [31:0]   ticks_out;

  // divider
  logic [38:0] dq;   // dividend shifting into quotient
  logic [31:0] drem;
  logic [31:0] dden;
  logic [5:0]  dcnt;

  // effective task count clamped to 1..TASK_SLOTS
  logic [CW-1:0] n;
  always_comb begin
    if (tasks_cfg == 5'd0) n = CW'(1);
    else if (32'(tasks_cfg) > 32'(TASK_SLOTS)) n = CW'(TASK_SLOTS);
    else n = CW'(tasks_cfg);
  end

  logic id_ok, id_ok_l;
  logic [IW-1:0] rid;
  assign id_ok = {28'd0, req.task_id} < 32'(n);
  assign rid   = IW'(req.task_id);

  logic cnd_hit;
  assign cnd_hit = tstate[IW'(cnd)] == rrts_pkg::ST_READY ||
                   tstate[IW'(cnd)] == rrts_pkg::ST_RUNNING;

  logic [IW-1:0] wslot;
  assign wslot = IW'(k);

  // percent product: run delta * 100 as 39 bits
  logic [31:0] dr, dt;
  assign dt = systime - ltot[rid];
  assign dr = runt[rid] - lrun[rid];

  logic [32:0] trial;
  assign trial = {drem, dq[38]} - {1'b0, dden};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        tstate[i] <= rrts_pkg::ST_READY;
        wake[i] <= '0; runt[i] <= '0; ltot[i] <= '0; lrun[i] <= '0;
      end
      systime <= '0; cur <= '0; cur_ok <= 1'b0;
      tasks_cfg <= 5'd1; step_cfg <= 10'd1;
      need_sched <= 1'b0; need_div <= 1'b0;
      k <= '0; cnd <= '0; found <= 1'b0; stat <= 1'b0; sw <= 1'b0;
      rsp <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == rrts_pkg::CFG_TASKS) tasks_cfg <= cfg_data[4:0];
        else step_cfg <= cfg_data;
      end
      if (cmd.load) begin
        tid <= req.task_id; id_ok_l <= id_ok;
        stat <= 1'b0; sw <= 1'b0; need_sched <= 1'b0; need_div <= 1'b0;
        ticks_out <= '0; k <= '0; found <= 1'b0;
        cnd <= cur_ok ? CW'(cur) + CW'(1) : '0;
        case (rrts_pkg::opcode_t'(req.opcode))
          rrts_pkg::OP_TICK: begin
            if (cur_ok) runt[cur] <= runt[cur] + 32'(step_cfg);
            systime <= systime + 32'(step_cfg);
            need_sched <= 1'b1;
          end
          rrts_pkg::OP_YIELD: need_sched <= 1'b1;
          rrts_pkg::OP_SLEEP, rrts_pkg::OP_EXIT: begin
            if (cur_ok && cur != '0) begin
              tstate[cur] <= (req.opcode == rrts_pkg::OP_SLEEP) ?
                             rrts_pkg::ST_BLOCKED : rrts_pkg::ST_TERMINATED;
              if (req.opcode == rrts_pkg::OP_SLEEP) wake[cur] <= systime + req.sleep_ms;
              need_sched <= 1'b1;
            end else stat <= 1'b1;
          end
          rrts_pkg::OP_SUSPEND, rrts_pkg::OP_TERMINATE: begin
            if (req.task_id != 4'd0 && id_ok) begin
              tstate[rid] <= (req.opcode == rrts_pkg::OP_SUSPEND) ?
                             rrts_pkg::ST_SUSPENDED : rrts_pkg::ST_TERMINATED;
              need_sched <= cur_ok && rid == cur;
            end else stat <= 1'b1;
          end
          rrts_pkg::OP_RESUME: begin
            if (req.task_id != 4'd0 && id_ok && tstate[rid] == rrts_pkg::ST_SUSPENDED)
              tstate[rid] <= rrts_pkg::ST_READY;
            else stat <= 1'b1;
          end
          default: begin
            if (!id_ok) stat <= 1'b1;
            else begin
              ticks_out <= runt[rid];
              if (dt != 32'd0) begin
                need_div <= 1'b1;
                dden <= dt;
                dq <= {7'd0, dr} * 39'(rrts_pkg::PCT_SCALE);
                ltot[rid] <= systime;
                lrun[rid] <= runt[rid];
              end
            end
          end
        endcase
      end
      if (cmd.wake_step) begin
        if (tstate[wslot] == rrts_pkg::ST_BLOCKED && systime >= wake[wslot])
          tstate[wslot] <= rrts_pkg::ST_READY;
        k <= (k + CW'(1) == n) ? CW'(1) : k + CW'(1);
      end
      // start slot beyond n (n lowered): fold it down first, then test
      if (cmd.pick_step && !found) begin
        if (cnd >= n) cnd <= cnd - n;
        else begin
          if (cnd_hit) begin
            found <= 1'b1;
            pick_idx <= IW'(cnd);
          end
          cnd <= (cnd + CW'(1) == n) ? '0 : cnd + CW'(1);
          k <= k + CW'(1);
        end
      end
      if (cmd.commit && found && !(cur_ok && pick_idx == cur)) begin
        if (cur_ok && tstate[cur] == rrts_pkg::ST_RUNNING) tstate[cur] <= rrts_pkg::ST_READY;
        tstate[pick_idx] <= rrts_pkg::ST_RUNNING;
        cur <= pick_idx; cur_ok <= 1'b1; sw <= 1'b1;
      end
      if (cmd.div_start) begin
        drem <= '0; dcnt <= '0;
      end
      if (cmd.div_step) begin
        if (!trial[32]) begin
          drem <= trial[31:0];
          dq <= {dq[37:0], 1'b1};
        end else begin
          drem <= {drem[30:0], dq[38]};
          dq <= {dq[37:0], 1'b0};
        end
        dcnt <= dcnt + 6'd1;
      end
      if (cmd.finish) begin
        rsp.running_task <= 4'(cur);
        rsp.running_valid <= cur_ok;
        rsp.switched <= sw;
        rsp.status <= stat;
        rsp.usage_percent <= (need_div) ?
          ((dq > 39'(rrts_pkg::PCT_SCALE)) ? 7'(rrts_pkg::PCT_SCALE) : dq[6:0]) : 7'd0;
        rsp.task_run_ticks <= ticks_out;
        rsp.addressed_state <= id_ok_l ? tstate[IW'(tid)] : rrts_pkg::ST_TERMINATED;
      end
    end
  end

  // wake scan starts at slot 0 after load (k=0), wraps k to 1 for the pick pass
  assign sts.need_sched = need_sched;
  assign sts.need_div   = need_div;
  assign sts.scan_last  = cmd.wake_step ? (k + CW'(1) == n) : (k == n && cnd < n);
  assign sts.pick_found = found;
  assign sts.div_last   = (dcnt == 6'd38);

  a_cur_running: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && cur_ok && sw |-> tstate[cur] == rrts_pkg::ST_RUNNING)
    else $error("switched task not running");
  a_sw_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && found |=> cur_ok)
    else $error("commit left no task");
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> dcnt <= 6'd38)
    else $error("divider overran");

endmodule

FILE: rtl/round_robin_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_top: hardware round-robin task scheduler
// Applies one scheduler request and returns one response per request.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry a request (opcode, task_id, sleep_ms).
//   out_valid/out_ready carry the response (running task, switch flag,
//   status, usage percent, run ticks, addressed task state).
//   cfg_we/cfg_idx/cfg_data write tasks_in_use (0) and tick_step (1);
//   write only while no request is in flight.
// Sequencing: one request at a time. A request that reschedules walks the
//   task slots twice (wake pass, pick pass), n being the task count, and
//   first folds the start slot below n when the running task sits beyond
//   a lowered task count.
//   A usage query runs a 39-step shift-subtract divider.
//   Other opcodes go straight to the response.
// Reset (rst, synchronous): all tasks ready, times and counters zero,
//   no task running, tasks_in_use 1, tick_step 1.
// Stall: the response stays in the output register until taken; the
//   next request is accepted once it is taken.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_top #(
  parameter int TASK_SLOTS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rrts_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rrts_pkg::rsp_t  out_data,
  input  logic            cfg_we,
  input  logic            cfg_idx,
  input  logic [9:0]      cfg_data
);

  rrts_pkg::cmd_t cmd;
  rrts_pkg::sts_t sts;
  logic idle;

  assign in_ready = idle && !out_valid;

  // response register: set on finish, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.finish) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  rrts_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_valid && in_ready),
    .out_busy(out_valid && !out_ready), .sts(sts), .cmd(cmd), .idle(idle)
  );

  rrts_dp #(.TASK_SLOTS(TASK_SLOTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .req(in_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .sts(sts), .rsp(out_data)
  );

  a_one_resp: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("response dropped");
  a_no_accept_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("accepted with response pending");
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !out_valid || out_ready)
    else $error("response overwritten");

endmodule
